// ===== design/assert_macros.svh =====
// assertion macros used by the top-level design file
// no dependencies; included by the top level

`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, masked during reset
`define KARD_ASSERT_IMP(name, clk_s, rst_s, ante, cons) \
    name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, masked during reset
`define KARD_ASSERT_NEXT(name, clk_s, rst_s, ante, cons) \
    name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/kard_pkg.sv =====
// shared constants and types for the keyboard adjacency run detector
// no dependencies; used by the channel interfaces and the top level

package kard_pkg;

    localparam int MaxLengthDefault     = 256;
    localparam int MaxDirectionsDefault = 9;
    localparam int KeyCountDefault      = 256;

    localparam int ByteW    = 8;
    localparam int DirW     = 4;
    localparam int TokW     = 2;
    localparam int CfgDataW = 4;

    localparam logic [DirW-1:0] NoneDir   = 4'd15;
    localparam logic [15:0]     TokenFill = 16'hFFFF;

    localparam logic [TokW-1:0] TokenWidthReset     = 2'd2;
    localparam logic [DirW-1:0] DirectionCountReset = 4'd7;

    typedef enum logic
    {
        OP_LOAD = 1'b0,
        OP_BYTE = 1'b1
    } opcode_t;

    typedef enum logic
    {
        CFG_TOKEN_WIDTH     = 1'b0,
        CFG_DIRECTION_COUNT = 1'b1
    } cfg_index_t;

endpackage

// ===== design/kard_if.sv =====
// valid/ready channel interfaces for input items and result items
// depends on kard_pkg

interface kard_item_if;
    import kard_pkg::*;

    logic             valid;
    logic             ready;
    logic             opcode;
    logic [ByteW-1:0] byte_value;
    logic [DirW-1:0]  direction;
    logic [ByteW-1:0] token_first;
    logic [ByteW-1:0] token_second;
    logic             last;

    modport source
    (
        output valid, opcode, byte_value, direction, token_first, token_second, last,
        input  ready
    );

    modport sink
    (
        input  valid, opcode, byte_value, direction, token_first, token_second, last,
        output ready
    );
endinterface

interface kard_result_if;
    import kard_pkg::*;

    logic             valid;
    logic             ready;
    logic [ByteW-1:0] run_start;
    logic [ByteW-1:0] run_end;
    logic [ByteW-1:0] turn_count;
    logic [ByteW-1:0] shifted_count;

    modport source
    (
        output valid, run_start, run_end, turn_count, shifted_count,
        input  ready
    );

    modport sink
    (
        input  valid, run_start, run_end, turn_count, shifted_count,
        output ready
    );
endinterface

// ===== design/keyboard_adjacency_run_detector.sv =====
// keyboard adjacency run detector top level; depends on kard_pkg, kard_if, assert_macros.svh
// throughput: one beat per cycle on the item channel while item ready is high, loads and
//   password bytes alike; a byte passes the compare stage register, then the output register
// reset: asynchronous, active low; then a clearing pass fills the adjacency memory with
//   0xFF bytes, one key row per cycle, with item ready held low
// config writes are taken at any time, including during the clearing pass

`include "assert_macros.svh"

module keyboard_adjacency_run_detector
#(
    parameter int MaxLength     = kard_pkg::MaxLengthDefault,
    parameter int MaxDirections = kard_pkg::MaxDirectionsDefault,
    parameter int KeyCount      = kard_pkg::KeyCountDefault
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    kard_item_if.sink                         item,
    kard_result_if.source                     result,
    input  logic                              cfg_we,
    input  kard_pkg::cfg_index_t              cfg_index,
    input  logic [kard_pkg::CfgDataW-1:0]     cfg_data
);
    import kard_pkg::*;

    localparam int PosW     = $clog2(MaxLength);
    localparam int KeyAddrW = $clog2(KeyCount);

    localparam logic [ByteW:0]    KeyLimit  = (ByteW+1)'(KeyCount);
    localparam logic [DirW-1:0]   DirLimit  = DirW'(MaxDirections);
    localparam logic [PosW-1:0]   PosFinal  = PosW'(MaxLength - 1);
    localparam logic [KeyAddrW-1:0] KeyFinal = KeyAddrW'(KeyCount - 1);

    typedef logic [MaxDirections-1:0][15:0] row_t;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [TokW-1:0] tw_reg;
    logic [DirW-1:0] dc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tw_reg <= TokenWidthReset;
            dc_reg <= DirectionCountReset;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TOKEN_WIDTH:     tw_reg <= cfg_data[TokW-1:0];
                CFG_DIRECTION_COUNT: dc_reg <= cfg_data[DirW-1:0];
                default:             ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // clearing pass after reset: one key row per cycle
    // ------------------------------------------------------------------
    logic                clearing_reg;
    logic                clearing_next;
    logic [KeyAddrW-1:0] clear_idx_reg;
    logic [KeyAddrW-1:0] clear_idx_next;

    always_comb
    begin
        clearing_next  = clearing_reg;
        clear_idx_next = clear_idx_reg;
        if (clearing_reg)
        begin
            clear_idx_next = clear_idx_reg + KeyAddrW'(1);
            if (clear_idx_reg == KeyFinal)
            begin
                clearing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clear_idx_reg <= '0;
        end
        else
        begin
            clearing_reg  <= clearing_next;
            clear_idx_reg <= clear_idx_next;
        end
    end

    // ------------------------------------------------------------------
    // handshake: the compare stage holds one password byte; it moves on
    // whenever the output register is free or being emptied
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic s1_valid_next;
    logic result_valid_reg;
    logic result_valid_next;
    logic advance;
    logic accept;
    logic accept_byte;
    logic load_we;

    assign advance    = s1_valid_reg && (!result_valid_reg || result.ready);
    assign item.ready = !clearing_reg && (!s1_valid_reg || advance);
    assign accept     = item.valid && item.ready;
    assign accept_byte = accept && (item.opcode == OP_BYTE);

    // loads outside the table are dropped
    assign load_we = accept && (item.opcode == OP_LOAD)
                     && ({1'b0, item.byte_value} < KeyLimit)
                     && (item.direction < DirLimit);

    // ------------------------------------------------------------------
    // front end: key of the previous password byte addresses the memory
    // ------------------------------------------------------------------
    logic [ByteW-1:0] prev_key_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_key_reg <= '0;
        end
        else if (accept_byte)
        begin
            prev_key_reg <= item.byte_value;
        end
    end

    // ------------------------------------------------------------------
    // adjacency memory: one row per key, one 16-bit token per direction
    // low byte unshifted neighbour, high byte shifted neighbour
    // a load writes at its own acceptance, so a later byte always sees it
    // ------------------------------------------------------------------
    row_t mem [KeyCount];
    row_t row_reg;
    logic key_oor_reg;

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            mem[clear_idx_reg] <= {MaxDirections{TokenFill}};
        end
        else if (load_we)
        begin
            for (int d = 0; d < MaxDirections; d++)
            begin
                if (item.direction == DirW'(d))
                begin
                    mem[item.byte_value[KeyAddrW-1:0]][d] <= {item.token_second, item.token_first};
                end
            end
        end
        if (accept_byte)
        begin
            row_reg     <= mem[prev_key_reg[KeyAddrW-1:0]];
            key_oor_reg <= ({1'b0, prev_key_reg} >= KeyLimit);
        end
    end

    // compare stage payload
    logic [ByteW-1:0] s1_byte_reg;
    logic             s1_last_reg;

    always_ff @(posedge clk)
    begin
        if (accept_byte)
        begin
            s1_byte_reg <= item.byte_value;
            s1_last_reg <= item.last;
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept_byte)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // run state
    // ------------------------------------------------------------------
    logic             have_prev_reg;
    logic             have_prev_next;
    logic [PosW-1:0]  pos_reg;
    logic [PosW-1:0]  pos_next;
    logic [PosW-1:0]  start_reg;
    logic [PosW-1:0]  start_next;
    logic [DirW-1:0]  last_dir_reg;
    logic [DirW-1:0]  last_dir_next;
    logic [ByteW-1:0] turns_reg;
    logic [ByteW-1:0] turns_next;
    logic [ByteW-1:0] shifts_reg;
    logic [ByteW-1:0] shifts_next;

    // ------------------------------------------------------------------
    // direction search: all directions compared at once, lowest hit wins,
    // unshifted byte checked before shifted within a direction
    // ------------------------------------------------------------------
    logic [DirW-1:0]          ndir;
    logic [MaxDirections-1:0] lo_hit;
    logic [MaxDirections-1:0] hi_hit;
    logic [15:0]              tok;
    logic                     found;
    logic                     shifted;
    logic [DirW-1:0]          hit_dir;

    always_comb
    begin
        ndir = (dc_reg > DirLimit) ? DirLimit : dc_reg;
        for (int d = 0; d < MaxDirections; d++)
        begin
            tok       = key_oor_reg ? TokenFill : row_reg[d];
            lo_hit[d] = (DirW'(d) < ndir) && (tok[7:0] == s1_byte_reg);
            hi_hit[d] = (DirW'(d) < ndir) && tw_reg[1] && (tok[15:8] == s1_byte_reg);
        end
        found   = |(lo_hit | hi_hit);
        shifted = 1'b0;
        hit_dir = '0;
        for (int d = MaxDirections - 1; d >= 0; d--)
        begin
            if (lo_hit[d] || hi_hit[d])
            begin
                hit_dir = DirW'(d);
                shifted = !lo_hit[d];
            end
        end
    end

    // ------------------------------------------------------------------
    // run bookkeeping and result selection
    // ------------------------------------------------------------------
    logic             step;
    logic             miss;
    logic             end_item;
    logic [PosW-1:0]  span;
    logic             emit_miss;
    logic             emit_end;
    logic             emit;
    logic [ByteW-1:0] turns_upd;
    logic [ByteW-1:0] shifts_upd;

    logic [ByteW-1:0] run_start_reg;
    logic [ByteW-1:0] run_start_next;
    logic [ByteW-1:0] run_end_reg;
    logic [ByteW-1:0] run_end_next;
    logic [ByteW-1:0] turn_count_reg;
    logic [ByteW-1:0] turn_count_next;
    logic [ByteW-1:0] shifted_count_reg;
    logic [ByteW-1:0] shifted_count_next;

    always_comb
    begin
        step     = have_prev_reg && found;
        miss     = have_prev_reg && !found;
        end_item = s1_last_reg || (pos_reg == PosFinal);
        span     = pos_reg - start_reg;

        turns_upd  = turns_reg + ByteW'(hit_dir != last_dir_reg);
        shifts_upd = shifts_reg + ByteW'(shifted);

        // broken run: report what came before this byte
        emit_miss = miss && (span > PosW'(2));
        // password end or final position inside a live run: report up to this byte
        emit_end  = end_item && step && (span >= PosW'(2));
        emit      = emit_miss || emit_end;

        have_prev_next = have_prev_reg;
        pos_next       = pos_reg;
        start_next     = start_reg;
        last_dir_next  = last_dir_reg;
        turns_next     = turns_reg;
        shifts_next    = shifts_reg;

        if (advance)
        begin
            if (end_item)
            begin
                have_prev_next = 1'b0;
                pos_next       = '0;
                start_next     = '0;
                last_dir_next  = NoneDir;
                turns_next     = '0;
                shifts_next    = '0;
            end
            else if (step)
            begin
                have_prev_next = 1'b1;
                pos_next       = pos_reg + PosW'(1);
                last_dir_next  = hit_dir;
                turns_next     = turns_upd;
                shifts_next    = shifts_upd;
            end
            else
            begin
                // first byte or broken run: a new run starts here
                have_prev_next = 1'b1;
                pos_next       = pos_reg + PosW'(1);
                start_next     = pos_reg;
                last_dir_next  = NoneDir;
                turns_next     = '0;
                shifts_next    = '0;
            end
        end

        run_start_next     = run_start_reg;
        run_end_next       = run_end_reg;
        turn_count_next    = turn_count_reg;
        shifted_count_next = shifted_count_reg;
        result_valid_next  = result_valid_reg && !result.ready;

        if (advance)
        begin
            result_valid_next = emit;
            run_start_next    = ByteW'(start_reg);
            if (emit_miss)
            begin
                run_end_next       = ByteW'(pos_reg - PosW'(1));
                turn_count_next    = turns_reg;
                shifted_count_next = shifts_reg;
            end
            else
            begin
                run_end_next       = ByteW'(pos_reg);
                turn_count_next    = turns_upd;
                shifted_count_next = shifts_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            have_prev_reg    <= 1'b0;
            pos_reg          <= '0;
            start_reg        <= '0;
            last_dir_reg     <= NoneDir;
            turns_reg        <= '0;
            shifts_reg       <= '0;
        end
        else
        begin
            s1_valid_reg     <= s1_valid_next;
            result_valid_reg <= result_valid_next;
            have_prev_reg    <= have_prev_next;
            pos_reg          <= pos_next;
            start_reg        <= start_next;
            last_dir_reg     <= last_dir_next;
            turns_reg        <= turns_next;
            shifts_reg       <= shifts_next;
        end
    end

    // result payload needs no reset
    always_ff @(posedge clk)
    begin
        run_start_reg     <= run_start_next;
        run_end_reg       <= run_end_next;
        turn_count_reg    <= turn_count_next;
        shifted_count_reg <= shifted_count_next;
    end

    assign result.valid         = result_valid_reg;
    assign result.run_start     = run_start_reg;
    assign result.run_end       = run_end_reg;
    assign result.turn_count    = turn_count_reg;
    assign result.shifted_count = shifted_count_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `KARD_ASSERT_IMP(a_no_accept_while_clearing, clk, rst_n, clearing_reg, !item.ready)
    `KARD_ASSERT_IMP(a_idle_run_is_clear, clk, rst_n, !have_prev_reg, last_dir_reg == NoneDir && turns_reg == '0 && shifts_reg == '0)
    `KARD_ASSERT_NEXT(a_emit_reaches_output, clk, rst_n, advance && emit, result.valid)
    `KARD_ASSERT_IMP(a_start_not_past_pos, clk, rst_n, have_prev_reg, start_reg <= pos_reg)

endmodule
